/* hw/rtl/mkm_pkg.sv */
`default_nettype none

package mkm_pkg;

  // Key code map: directions 0..3, wheels 4..7, accelerators 8..10, buttons 11..15
  localparam logic [3:0] KEY_WHEEL_BASE  = 4'd4;
  localparam logic [3:0] KEY_ACCEL_BASE  = 4'h8;
  localparam logic [3:0] KEY_BUTTON_BASE = 4'd11;

  // Item kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_BASE_SPEED     = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED      = 3'd1;
  localparam logic [2:0] CFG_RAMP_TIME      = 3'd2;
  localparam logic [2:0] CFG_MOVE_DELAY     = 3'd3;
  localparam logic [2:0] CFG_MOVE_INTERVAL  = 3'd4;
  localparam logic [2:0] CFG_WHEEL_STEP     = 3'd5;
  localparam logic [2:0] CFG_WHEEL_DELAY    = 3'd6;
  localparam logic [2:0] CFG_WHEEL_INTERVAL = 3'd7;

  // Configuration reset values
  localparam logic [6:0]  RST_BASE_SPEED     = 7'd5;
  localparam logic [6:0]  RST_MAX_SPEED      = 7'd20;
  localparam logic [15:0] RST_RAMP_TIME      = 16'd1000;
  localparam logic [15:0] RST_MOVE_DELAY     = 16'd10;
  localparam logic [15:0] RST_MOVE_INTERVAL  = 16'd16;
  localparam logic [6:0]  RST_WHEEL_STEP     = 7'd1;
  localparam logic [15:0] RST_WHEEL_DELAY    = 16'd10;
  localparam logic [15:0] RST_WHEEL_INTERVAL = 16'd80;

  // Diagonal scale 181/256
  localparam logic [7:0] DIAG_SCALE = 8'd181;

  // Direction mask bits (dirs and wheels share the order)
  localparam int unsigned DIR_UP    = 0;
  localparam int unsigned DIR_DOWN  = 1;
  localparam int unsigned DIR_LEFT  = 2;
  localparam int unsigned DIR_RIGHT = 3;

endpackage

`default_nettype wire

/* hw/rtl/mouse_keys_motion_generator_unit.sv */
`default_nettype none

// Channel | Signals                                   | Direction
// --------+-------------------------------------------+----------
// in      | in_valid_i/in_ready_o, kind, key,         | into block
//         | pressed, time_ms                          |
// out     | out_valid_o/out_ready_i, button_mask,     | out of block
//         | x/y/wheel/pan_move, last                  |
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | into block
//
// An item is taken in the idle state; its results then leave one by one from the emit state.
// A motion result first passes the prep state, which picks the speed; on the speed ramp it runs
// a bit-serial shift-add multiply of span by elapsed time, then a restoring divide
// by the ramp time, one quotient bit per cycle.
// Reset clears all held keys, timers and the output register at once.
// A stalled output holds the block in its emit state; new items wait.

module mouse_keys_motion_generator_unit #(
  parameter logic [6:0] SPEED_SLOW = 7'd1,
  parameter logic [6:0] SPEED_MED  = 7'd4,
  parameter logic [6:0] SPEED_FAST = 7'd12
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // input items
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                kind_i,
  input  wire  [3:0]         key_i,
  input  wire                pressed_i,
  input  wire  [31:0]        time_ms_i,
  // result items
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [4:0]         button_mask_o,
  output logic signed [7:0]  x_move_o,
  output logic signed [7:0]  y_move_o,
  output logic signed [7:0]  wheel_move_o,
  output logic signed [7:0]  pan_move_o,
  output logic               last_o,
  // configuration
  input  wire                cfg_we_i,
  input  wire  [2:0]         cfg_idx_i,
  input  wire  [15:0]        cfg_data_i
);
  import mkm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_e;

  // Configuration registers
  logic [6:0]  base_speed_q, max_speed_q, wheel_step_q;
  logic [15:0] ramp_time_q, move_delay_q, move_interval_q, wheel_delay_q, wheel_interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q     <= RST_BASE_SPEED;
      max_speed_q      <= RST_MAX_SPEED;
      ramp_time_q      <= RST_RAMP_TIME;
      move_delay_q     <= RST_MOVE_DELAY;
      move_interval_q  <= RST_MOVE_INTERVAL;
      wheel_step_q     <= RST_WHEEL_STEP;
      wheel_delay_q    <= RST_WHEEL_DELAY;
      wheel_interval_q <= RST_WHEEL_INTERVAL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE_SPEED:     base_speed_q     <= cfg_data_i[6:0];
        CFG_MAX_SPEED:      max_speed_q      <= cfg_data_i[6:0];
        CFG_RAMP_TIME:      ramp_time_q      <= cfg_data_i;
        CFG_MOVE_DELAY:     move_delay_q     <= cfg_data_i;
        CFG_MOVE_INTERVAL:  move_interval_q  <= cfg_data_i;
        CFG_WHEEL_STEP:     wheel_step_q     <= cfg_data_i[6:0];
        CFG_WHEEL_DELAY:    wheel_delay_q    <= cfg_data_i;
        CFG_WHEEL_INTERVAL: wheel_interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // State
  state_e      state_q;
  logic [3:0]  dirs_q, wheels_q;
  logic [2:0]  accel_q;
  logic [4:0]  buttons_q;
  logic        btn_chg_q;
  logic [31:0] next_move_q, next_wheel_q, start_q, now_q;
  logic        pend_btn_q, pend_mot_q, pend_whl_q;
  logic [6:0]  speed_q;
  // serial multiply / divide datapath
  logic [15:0] mcand_q;
  logic [6:0]  mplier_q;
  logic [22:0] acc_q;
  logic [21:0] divisor_q;
  logic [6:0]  quot_q;
  logic [2:0]  cnt_q;
  // output register
  logic              out_valid_q, last_q;
  logic [4:0]        bmask_q;
  logic signed [7:0] x_q, y_q, w_q, p_q;

  // Key event mask update
  logic [3:0] dirs_d, wheels_d;
  logic [2:0] accel_d;
  logic [4:0] buttons_d;
  logic [3:0] key_bit4;
  logic [2:0] btn_idx;
  logic [4:0] key_bit5;
  logic       is_button;

  always_comb begin
    key_bit4  = 4'b0001 << key_i[1:0];
    btn_idx   = 3'(key_i - KEY_BUTTON_BASE);
    key_bit5  = 5'b00001 << btn_idx;
    is_button = key_i >= KEY_BUTTON_BASE;
    dirs_d    = dirs_q;
    wheels_d  = wheels_q;
    accel_d   = accel_q;
    buttons_d = buttons_q;
    if (key_i < KEY_WHEEL_BASE) begin
      dirs_d = pressed_i ? (dirs_q | key_bit4) : (dirs_q & ~key_bit4);
    end else if (key_i < KEY_ACCEL_BASE) begin
      wheels_d = pressed_i ? (wheels_q | key_bit4) : (wheels_q & ~key_bit4);
    end else if (!is_button) begin
      accel_d = pressed_i ? (accel_q | key_bit4[2:0]) : (accel_q & ~key_bit4[2:0]);
    end else begin
      buttons_d = pressed_i ? (buttons_q | key_bit5) : (buttons_q & ~key_bit5);
    end
  end

  // Which results this item fires
  logic [31:0] move_diff, wheel_diff;
  logic        mot_fire, whl_fire;

  always_comb begin
    move_diff  = time_ms_i - next_move_q;
    wheel_diff = time_ms_i - next_wheel_q;
    if (kind_i == KIND_KEY) begin
      mot_fire = (dirs_q == 4'd0) && (dirs_d != 4'd0);
      whl_fire = (wheels_q == 4'd0) && (wheels_d != 4'd0);
    end else begin
      mot_fire = (dirs_q != 4'd0) && !move_diff[31];
      whl_fire = (wheels_q != 4'd0) && !wheel_diff[31];
    end
  end

  // Ramp terms
  logic [31:0] elapsed;
  logic [6:0]  span;
  logic        ramp_done;

  always_comb begin
    elapsed   = now_q - start_q;
    span      = (max_speed_q > base_speed_q) ? (max_speed_q - base_speed_q) : 7'd0;
    ramp_done = elapsed >= {16'd0, ramp_time_q};
  end

  // Multiply and divide steps
  logic [22:0] mul_next;
  logic        div_take;
  logic [6:0]  quot_d;

  always_comb begin
    mul_next = {acc_q[21:0], 1'b0} + (mplier_q[6] ? {7'd0, mcand_q} : 23'd0);
    div_take = acc_q >= {1'b0, divisor_q};
    quot_d   = {quot_q[5:0], div_take};
  end

  // Motion vector from speed
  logic [14:0]       diag_prod;
  logic [6:0]        diag_mag, mag;
  logic              x_on, y_on, diag;
  logic signed [7:0] mot_x, mot_y, whl_w, whl_p, step_s;

  always_comb begin
    x_on      = dirs_q[DIR_RIGHT] ^ dirs_q[DIR_LEFT];
    y_on      = dirs_q[DIR_DOWN] ^ dirs_q[DIR_UP];
    diag      = x_on && y_on && (speed_q != 7'd0);
    diag_prod = speed_q * DIAG_SCALE;
    diag_mag  = (diag_prod[14:8] == 7'd0) ? 7'd1 : diag_prod[14:8];
    mag       = diag ? diag_mag : speed_q;
    mot_x = 8'sd0;
    mot_y = 8'sd0;
    if (x_on) begin
      mot_x = dirs_q[DIR_RIGHT] ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
    end
    if (y_on) begin
      mot_y = dirs_q[DIR_DOWN] ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
    end
    step_s = $signed({1'b0, wheel_step_q});
    whl_w  = 8'sd0;
    whl_p  = 8'sd0;
    if (wheels_q[DIR_UP] ^ wheels_q[DIR_DOWN]) begin
      whl_w = wheels_q[DIR_UP] ? step_s : -step_s;
    end
    if (wheels_q[DIR_RIGHT] ^ wheels_q[DIR_LEFT]) begin
      whl_p = wheels_q[DIR_RIGHT] ? step_s : -step_s;
    end
  end

  logic out_free;
  logic pend_any;
  logic emit_go;
  assign out_free = !out_valid_q || out_ready_i;
  assign pend_any = pend_btn_q || pend_mot_q || pend_whl_q;
  // a result is loaded into the output register this cycle
  assign emit_go  = (state_q == S_EMIT) && pend_any && out_free;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dirs_q       <= '0;
      wheels_q     <= '0;
      accel_q      <= '0;
      buttons_q    <= '0;
      btn_chg_q    <= 1'b0;
      next_move_q  <= '0;
      next_wheel_q <= '0;
      start_q      <= '0;
      now_q        <= '0;
      pend_btn_q   <= 1'b0;
      pend_mot_q   <= 1'b0;
      pend_whl_q   <= 1'b0;
      speed_q      <= '0;
      mcand_q      <= '0;
      mplier_q     <= '0;
      acc_q        <= '0;
      divisor_q    <= '0;
      quot_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      last_q       <= 1'b0;
      bmask_q      <= '0;
      x_q          <= 8'sd0;
      y_q          <= 8'sd0;
      w_q          <= 8'sd0;
      p_q          <= 8'sd0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            now_q      <= time_ms_i;
            pend_mot_q <= mot_fire;
            pend_whl_q <= whl_fire;
            if (kind_i == KIND_KEY) begin
              dirs_q     <= dirs_d;
              wheels_q   <= wheels_d;
              accel_q    <= accel_d;
              buttons_q  <= buttons_d;
              pend_btn_q <= 1'b0;
              if (is_button) begin
                btn_chg_q <= 1'b1;
              end
              if (mot_fire) begin
                start_q     <= time_ms_i;
                next_move_q <= time_ms_i + {16'd0, move_delay_q};
              end
              if (whl_fire) begin
                next_wheel_q <= time_ms_i + {16'd0, wheel_delay_q};
              end
            end else begin
              pend_btn_q <= btn_chg_q;
              btn_chg_q  <= 1'b0;
              if (mot_fire) begin
                next_move_q <= time_ms_i + {16'd0, move_interval_q};
              end
              if (whl_fire) begin
                next_wheel_q <= time_ms_i + {16'd0, wheel_interval_q};
              end
            end
            state_q <= mot_fire ? S_PREP : S_EMIT;
          end
        end
        // Pinned speed, ramp end, or start the serial multiply
        S_PREP: begin
          if (accel_q[0]) begin
            speed_q <= SPEED_SLOW;
            state_q <= S_EMIT;
          end else if (accel_q[1]) begin
            speed_q <= SPEED_MED;
            state_q <= S_EMIT;
          end else if (accel_q[2]) begin
            speed_q <= SPEED_FAST;
            state_q <= S_EMIT;
          end else if (ramp_done) begin
            speed_q <= max_speed_q;
            state_q <= S_EMIT;
          end else begin
            mcand_q  <= elapsed[15:0];
            mplier_q <= span;
            acc_q    <= '0;
            quot_q   <= '0;
            cnt_q    <= 3'd6;
            state_q  <= S_MUL;
          end
        end
        // span * elapsed, one multiplier bit per cycle, MSB first
        S_MUL: begin
          acc_q    <= mul_next;
          mplier_q <= {mplier_q[5:0], 1'b0};
          if (cnt_q == 3'd0) begin
            divisor_q <= {ramp_time_q, 6'd0};
            cnt_q     <= 3'd6;
            state_q   <= S_DIV;
          end else begin
            cnt_q <= cnt_q - 3'd1;
          end
        end
        // product / ramp_time, one quotient bit per cycle
        S_DIV: begin
          if (div_take) begin
            acc_q <= acc_q - {1'b0, divisor_q};
          end
          divisor_q <= {1'b0, divisor_q[21:1]};
          quot_q    <= quot_d;
          if (cnt_q == 3'd0) begin
            speed_q <= base_speed_q + quot_d;
            state_q <= S_EMIT;
          end else begin
            cnt_q <= cnt_q - 3'd1;
          end
        end
        // Hand out pending results in order: button, motion, wheel
        S_EMIT: begin
          if (!pend_any) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            bmask_q <= buttons_q;
            if (pend_btn_q) begin
              pend_btn_q <= 1'b0;
              x_q    <= 8'sd0;
              y_q    <= 8'sd0;
              w_q    <= 8'sd0;
              p_q    <= 8'sd0;
              last_q <= !(pend_mot_q || pend_whl_q);
              if (!(pend_mot_q || pend_whl_q)) begin
                state_q <= S_IDLE;
              end
            end else if (pend_mot_q) begin
              pend_mot_q <= 1'b0;
              x_q    <= mot_x;
              y_q    <= mot_y;
              w_q    <= 8'sd0;
              p_q    <= 8'sd0;
              last_q <= !pend_whl_q;
              if (!pend_whl_q) begin
                state_q <= S_IDLE;
              end
            end else begin
              pend_whl_q <= 1'b0;
              x_q     <= 8'sd0;
              y_q     <= 8'sd0;
              w_q     <= whl_w;
              p_q     <= whl_p;
              last_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign button_mask_o = bmask_q;
  assign x_move_o      = x_q;
  assign y_move_o      = y_q;
  assign wheel_move_o  = w_q;
  assign pan_move_o    = p_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

/* dv/tb_mouse_keys_motion_generator_unit.sv */
module tb_mouse_keys_motion_generator_unit;
  import mkm_pkg::*;

  localparam logic [6:0] SPEED_SLOW = 7'd1;
  localparam logic [6:0] SPEED_MED  = 7'd4;
  localparam logic [6:0] SPEED_FAST = 7'd12;

  // idle time after the last report before a register write or the end
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 21;
  localparam int unsigned STEADY_PHASE  = 3;

  // key codes
  localparam logic [3:0] K_UP      = 4'd0;
  localparam logic [3:0] K_DOWN    = 4'd1;
  localparam logic [3:0] K_LEFT    = 4'd2;
  localparam logic [3:0] K_RIGHT   = 4'd3;
  localparam logic [3:0] K_W_UP    = KEY_WHEEL_BASE;
  localparam logic [3:0] K_W_DOWN  = KEY_WHEEL_BASE + 4'd1;
  localparam logic [3:0] K_W_LEFT  = KEY_WHEEL_BASE + 4'd2;
  localparam logic [3:0] K_W_RIGHT = KEY_WHEEL_BASE + 4'd3;
  localparam logic [3:0] K_ACC0    = KEY_ACCEL_BASE;
  localparam logic [3:0] K_ACC1    = KEY_ACCEL_BASE + 4'd1;
  localparam logic [3:0] K_ACC2    = KEY_ACCEL_BASE + 4'd2;
  localparam logic [3:0] K_BTN1    = KEY_BUTTON_BASE;
  localparam logic [3:0] K_BTN5    = KEY_BUTTON_BASE + 4'd4;

  typedef struct packed {
    bit        kind;
    bit [3:0]  key;
    bit        pressed;
    bit [31:0] stamp_ms;
  } input_item_t;

  typedef struct packed {
    bit [4:0]        button_mask;
    bit signed [7:0] x_move;
    bit signed [7:0] y_move;
    bit signed [7:0] wheel_move;
    bit signed [7:0] pan_move;
    bit              last;
  } report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               kind_i;
  logic [3:0]         key_i;
  logic               pressed_i;
  logic [31:0]        time_ms_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [4:0]         button_mask_o;
  logic signed [7:0]  x_move_o;
  logic signed [7:0]  y_move_o;
  logic signed [7:0]  wheel_move_o;
  logic signed [7:0]  pan_move_o;
  logic               last_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;

  mouse_keys_motion_generator_unit #(
    .SPEED_SLOW(SPEED_SLOW),
    .SPEED_MED (SPEED_MED),
    .SPEED_FAST(SPEED_FAST)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .key_i        (key_i),
    .pressed_i    (pressed_i),
    .time_ms_i    (time_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .button_mask_o(button_mask_o),
    .x_move_o     (x_move_o),
    .y_move_o     (y_move_o),
    .wheel_move_o (wheel_move_o),
    .pan_move_o   (pan_move_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Mirrors held keys and timers, queues the reports each item should cause
  class motion_report_board;
    bit [6:0]  base_speed     = RST_BASE_SPEED;
    bit [6:0]  max_speed      = RST_MAX_SPEED;
    bit [15:0] ramp_ms        = RST_RAMP_TIME;
    bit [15:0] move_delay     = RST_MOVE_DELAY;
    bit [15:0] move_interval  = RST_MOVE_INTERVAL;
    bit [6:0]  wheel_step     = RST_WHEEL_STEP;
    bit [15:0] wheel_delay    = RST_WHEEL_DELAY;
    bit [15:0] wheel_interval = RST_WHEEL_INTERVAL;

    bit [3:0]  dirs;
    bit [3:0]  wheels;
    bit [4:0]  buttons;
    bit [2:0]  accel;
    bit        btn_report_due;
    bit [31:0] next_move_ms;
    bit [31:0] next_wheel_ms;
    bit [31:0] motion_start_ms;

    report_t     expected_reports[$];
    int unsigned errors;
    int unsigned reports_seen;
    int unsigned items_seen;
    int unsigned ticks_seen;

    task log_mismatch(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    function void set_reg(bit [2:0] idx, bit [15:0] val);
      case (idx)
        CFG_BASE_SPEED:     base_speed     = val[6:0];
        CFG_MAX_SPEED:      max_speed      = val[6:0];
        CFG_RAMP_TIME:      ramp_ms        = val;
        CFG_MOVE_DELAY:     move_delay     = val;
        CFG_MOVE_INTERVAL:  move_interval  = val;
        CFG_WHEEL_STEP:     wheel_step     = val[6:0];
        CFG_WHEEL_DELAY:    wheel_delay    = val;
        CFG_WHEEL_INTERVAL: wheel_interval = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // accelerator pins the speed, slowest wins; else linear ramp
    function int speed_at(bit [31:0] now);
      bit [31:0] elapsed;
      bit [31:0] span;
      if (accel[0]) return int'(SPEED_SLOW);
      if (accel[1]) return int'(SPEED_MED);
      if (accel[2]) return int'(SPEED_FAST);
      elapsed = now - motion_start_ms;
      if (elapsed >= {16'd0, ramp_ms}) return int'(max_speed);
      span = (max_speed > base_speed) ? 32'(max_speed - base_speed) : 32'd0;
      return int'(base_speed) + int'(span * elapsed / ramp_ms);
    endfunction

    function int clamp127(int v);
      return (v > 127) ? 127 : ((v < -127) ? -127 : v);
    endfunction

    function void push_report(int x, int y, int w, int p);
      report_t r;
      r.button_mask = buttons;
      r.x_move      = 8'(clamp127(x));
      r.y_move      = 8'(clamp127(y));
      r.wheel_move  = 8'(clamp127(w));
      r.pan_move    = 8'(clamp127(p));
      r.last        = 1'b0;
      expected_reports.push_back(r);
    endfunction

    function void predict_motion(bit [31:0] now);
      int s;
      int x;
      int y;
      s = speed_at(now);
      x = 0;
      y = 0;
      if (dirs[DIR_RIGHT]) x += s;
      if (dirs[DIR_LEFT])  x -= s;
      if (dirs[DIR_DOWN])  y += s;
      if (dirs[DIR_UP])    y -= s;
      // diagonal: scale toward zero, never below one unit
      if (x != 0 && y != 0) begin
        x = x * int'(DIAG_SCALE) / 256;
        y = y * int'(DIAG_SCALE) / 256;
        if (x == 0) x = dirs[DIR_RIGHT] ? 1 : -1;
        if (y == 0) y = dirs[DIR_DOWN] ? 1 : -1;
      end
      push_report(x, y, 0, 0);
    endfunction

    function void predict_wheel();
      int d;
      int w;
      int p;
      d = int'(wheel_step);
      w = 0;
      p = 0;
      if (wheels[DIR_UP])    w += d;
      if (wheels[DIR_DOWN])  w -= d;
      if (wheels[DIR_RIGHT]) p += d;
      if (wheels[DIR_LEFT])  p -= d;
      push_report(0, 0, w, p);
    endfunction

    function bit is_due(bit [31:0] now, bit [31:0] due_ms);
      bit [31:0] diff;
      diff = now - due_ms;
      return !diff[31];
    endfunction

    function void note_event(input_item_t it);
      bit [3:0]    old_dirs;
      bit [3:0]    old_wheels;
      int unsigned queued_n;
      report_t     tail;
      queued_n = expected_reports.size();
      items_seen++;
      if (it.kind == KIND_KEY) begin
        old_dirs   = dirs;
        old_wheels = wheels;
        if (it.key < KEY_WHEEL_BASE) begin
          dirs[it.key[1:0]] = it.pressed;
        end else if (it.key < KEY_ACCEL_BASE) begin
          wheels[it.key[1:0]] = it.pressed;
        end else if (it.key < KEY_BUTTON_BASE) begin
          accel[it.key - KEY_ACCEL_BASE] = it.pressed;
        end else begin
          buttons[it.key - KEY_BUTTON_BASE] = it.pressed;
          btn_report_due = 1'b1;
        end
        // first press moves at once and arms the repeat delay
        if (old_dirs == 4'd0 && dirs != 4'd0) begin
          motion_start_ms = it.stamp_ms;
          predict_motion(it.stamp_ms);
          next_move_ms = it.stamp_ms + move_delay;
        end
        if (old_wheels == 4'd0 && wheels != 4'd0) begin
          predict_wheel();
          next_wheel_ms = it.stamp_ms + wheel_delay;
        end
      end else begin
        ticks_seen++;
        if (btn_report_due) begin
          btn_report_due = 1'b0;
          push_report(0, 0, 0, 0);
        end
        if (dirs != 4'd0 && is_due(it.stamp_ms, next_move_ms)) begin
          predict_motion(it.stamp_ms);
          next_move_ms = it.stamp_ms + move_interval;
        end
        if (wheels != 4'd0 && is_due(it.stamp_ms, next_wheel_ms)) begin
          predict_wheel();
          next_wheel_ms = it.stamp_ms + wheel_interval;
        end
      end
      if (expected_reports.size() > queued_n) begin
        tail      = expected_reports.pop_back();
        tail.last = 1'b1;
        expected_reports.push_back(tail);
      end
    endfunction

    task compare_field(string fname, int got, int want);
      if (got != want)
        log_mismatch($sformatf("report %0d: %s is %0d, expected %0d",
                               reports_seen, fname, got, want));
    endtask

    task check_report(report_t got);
      report_t want;
      reports_seen++;
      if (expected_reports.size() == 0) begin
        log_mismatch($sformatf("report %0d arrived with nothing expected", reports_seen));
      end else begin
        want = expected_reports.pop_front();
        compare_field("button_mask", int'(got.button_mask), int'(want.button_mask));
        compare_field("x_move", int'(got.x_move), int'(want.x_move));
        compare_field("y_move", int'(got.y_move), int'(want.y_move));
        compare_field("wheel_move", int'(got.wheel_move), int'(want.wheel_move));
        compare_field("pan_move", int'(got.pan_move), int'(want.pan_move));
        compare_field("last", int'(got.last), int'(want.last));
      end
    endtask
  endclass

  motion_report_board board;
  report_t            seen_report;
  bit                 steady;
  bit [31:0]          now_ms;
  logic [15:0]        reg_plan [8];
  int unsigned        settings_applied;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side: check accepted reports, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_report.button_mask = button_mask_o;
      seen_report.x_move      = x_move_o;
      seen_report.y_move      = y_move_o;
      seen_report.wheel_move  = wheel_move_o;
      seen_report.pan_move    = pan_move_o;
      seen_report.last        = last_o;
      board.check_report(seen_report);
    end
    out_ready_i <= steady || ($urandom_range(99) >= 14);
  end

  // send one item; valid holds until accepted
  task automatic send_item(input input_item_t it);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= it.kind;
    key_i      <= it.key;
    pressed_i  <= it.pressed;
    time_ms_i  <= it.stamp_ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_event(it);
  endtask

  task automatic key_event(input logic [3:0] k, input bit p);
    input_item_t it;
    it.kind     = KIND_KEY;
    it.key      = k;
    it.pressed  = p;
    it.stamp_ms = now_ms;
    send_item(it);
  endtask

  task automatic tick_after(input int unsigned dt);
    input_item_t it;
    now_ms      += dt;
    it.kind     = KIND_TICK;
    it.key      = 4'd0;
    it.pressed  = 1'b0;
    it.stamp_ms = now_ms;
    send_item(it);
  endtask

  // mostly a random walk of keys and advancing ticks, some noise
  task automatic send_random_item();
    input_item_t it;
    int unsigned pick;
    pick        = $urandom_range(99);
    it.key      = 4'($urandom);
    it.pressed  = 1'($urandom);
    if (pick < 5) begin
      it.kind     = 1'($urandom);
      it.stamp_ms = $urandom;
    end else if (pick < 50) begin
      now_ms      += ($urandom_range(19) == 0) ? $urandom_range(70000) : $urandom_range(30);
      it.kind     = KIND_TICK;
      it.stamp_ms = now_ms;
    end else begin
      now_ms      += $urandom_range(4);
      it.kind     = KIND_KEY;
      it.stamp_ms = now_ms;
    end
    send_item(it);
  endtask

  // hold off input until every queued report has come out
  task automatic await_reports();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic drain_and_settle();
    await_reports();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_plan();
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= reg_plan[i];
      @(posedge clk_i);
      cfg_we_i   <= 1'b0;
      board.set_reg(3'(i), reg_plan[i]);
    end
    settings_applied++;
  endtask

  task automatic plan_settings(input int unsigned phase);
    case (phase)
      0: begin
        // base above max: ramp span clamps to zero; motion repeats on every tick
        reg_plan[CFG_BASE_SPEED]     = 16'd127;
        reg_plan[CFG_MAX_SPEED]      = 16'd0;
        reg_plan[CFG_RAMP_TIME]      = 16'hFFFF;
        reg_plan[CFG_MOVE_DELAY]     = 16'd0;
        reg_plan[CFG_MOVE_INTERVAL]  = 16'd0;
        reg_plan[CFG_WHEEL_STEP]     = 16'd127;
        reg_plan[CFG_WHEEL_DELAY]    = 16'hFFFF;
        reg_plan[CFG_WHEEL_INTERVAL] = 16'd0;
      end
      1: begin
        // zero ramp time: full speed at once; longest repeat waits
        reg_plan[CFG_BASE_SPEED]     = 16'd0;
        reg_plan[CFG_MAX_SPEED]      = 16'd127;
        reg_plan[CFG_RAMP_TIME]      = 16'd0;
        reg_plan[CFG_MOVE_DELAY]     = 16'hFFFF;
        reg_plan[CFG_MOVE_INTERVAL]  = 16'hFFFF;
        reg_plan[CFG_WHEEL_STEP]     = 16'd0;
        reg_plan[CFG_WHEEL_DELAY]    = 16'd0;
        reg_plan[CFG_WHEEL_INTERVAL] = 16'hFFFF;
      end
      default: begin
        reg_plan[CFG_BASE_SPEED]     = 16'($urandom_range(127));
        reg_plan[CFG_MAX_SPEED]      = 16'($urandom_range(127));
        reg_plan[CFG_RAMP_TIME]      = 16'($urandom_range(400));
        reg_plan[CFG_MOVE_DELAY]     = 16'($urandom_range(40));
        reg_plan[CFG_MOVE_INTERVAL]  = 16'($urandom_range(30));
        reg_plan[CFG_WHEEL_STEP]     = 16'($urandom_range(127));
        reg_plan[CFG_WHEEL_DELAY]    = 16'($urandom_range(40));
        reg_plan[CFG_WHEEL_INTERVAL] = 16'($urandom_range(60));
      end
    endcase
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    board        = new();
    steady       = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    kind_i      <= KIND_KEY;
    key_i       <= 4'd0;
    pressed_i   <= 1'b0;
    time_ms_i   <= 32'd0;
    out_ready_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_BASE_SPEED;
    cfg_data_i  <= 16'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings; time wraps to zero early on
    now_ms = 32'hFFFF_FFF6;
    key_event(K_UP, 1'b1);          // first press moves at once
    tick_after(5);                  // repeat not yet due
    tick_after(5);                  // due at time zero, across the wrap
    key_event(K_RIGHT, 1'b1);
    tick_after(16);                 // diagonal
    key_event(K_LEFT, 1'b1);
    tick_after(16);                 // opposing keys cancel x
    key_event(K_LEFT, 1'b0);
    key_event(K_ACC0, 1'b1);
    key_event(K_ACC2, 1'b1);
    tick_after(16);                 // slowest accel, diagonal keeps one unit
    key_event(K_ACC0, 1'b0);
    tick_after(16);                 // fast accel
    key_event(K_W_UP, 1'b1);        // first wheel step at once
    key_event(K_W_RIGHT, 1'b1);
    key_event(K_BTN1, 1'b1);
    key_event(K_BTN5, 1'b1);
    tick_after(80);                 // button, motion and wheel in one tick
    key_event(K_W_DOWN, 1'b1);      // wheel vertical cancels
    key_event(K_ACC1, 1'b1);
    tick_after(80);
    tick_after(0);                  // nothing due
    key_event(K_BTN5, 1'b0);
    key_event(K_W_LEFT, 1'b1);
    tick_after(1);

    // random phases, each with its own register settings
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain_and_settle();
      plan_settings(ph);
      program_plan();
      steady = (ph == STEADY_PHASE);
      now_ms = $urandom;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) await_reports();
        send_random_item();
      end
    end
    steady = 1'b0;
    drain_and_settle();

    $display("Sent %0d items (%0d ticks) under %0d register settings plus reset values.",
             board.items_seen, board.ticks_seen, settings_applied);
    $display("Checked %0d reports, %0d mismatches.", board.reports_seen, board.errors);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mkm_pkg.sv
hw/rtl/mouse_keys_motion_generator_unit.sv
dv/tb_mouse_keys_motion_generator_unit.sv
